>>> sv/hps_pkg.sv
package hps_pkg;

  localparam int MAX_TASKS = 1024;
  localparam int MAX_PES   = 16;
  localparam int TIME_W    = 32;

  localparam int TASK_W   = $clog2(MAX_TASKS);
  localparam int PE_W     = (MAX_PES > 1) ? $clog2(MAX_PES) : 1;
  localparam int PE_CNT_W = $clog2(MAX_PES + 1);
  localparam int WEIGHT_W = 16;
  localparam int COST_W   = 16;
  localparam int CFG_W    = 5;
  localparam int ENTRY_W  = PE_W + TIME_W;

  localparam logic [CFG_W-1:0] PE_COUNT_RESET = CFG_W'(4);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [PE_W-1:0]   pe_idx_t;

  // control for one step of the shared compare unit
  typedef struct packed {
    logic has_pred;
    logic home;
    logic in_use;
    logic first;
  } step_ctrl_t;

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] sum;
    begin
      sum = {1'b0, a} + {1'b0, b};
      sat_add = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end
  endfunction

endpackage

>>> sv/hps_if.sv
interface hps_in_if;
  import hps_pkg::*;

  logic                valid;
  logic                ready;
  logic [TASK_W-1:0]   task_id;
  logic [WEIGHT_W-1:0] task_weight;
  logic                has_pred;
  logic [TASK_W-1:0]   pred_id;
  logic [COST_W-1:0]   comm_cost;
  logic                last_pred;

  modport source (
    output valid, task_id, task_weight, has_pred, pred_id, comm_cost, last_pred,
    input  ready
  );
  modport sink (
    input  valid, task_id, task_weight, has_pred, pred_id, comm_cost, last_pred,
    output ready
  );
endinterface

interface hps_out_if;
  import hps_pkg::*;

  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] placed_task;
  logic [PE_W-1:0]   chosen_pe;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] finish_time;

  modport source (
    output valid, placed_task, chosen_pe, start_time, finish_time,
    input  ready
  );
  modport sink (
    input  valid, placed_task, chosen_pe, start_time, finish_time,
    output ready
  );
endinterface

>>> sv/heft_processor_selection.sv
// heft list scheduling, processor selection stage
//
// tasks arrive in priority order on in_ch, each as a run of items: one
// item per predecessor (pred_id, comm_cost), or a single item with
// has_pred low for a source task. last_pred marks the end of the run.
// a transfer happens on a rising edge with valid and ready both high.
// every item passes through a table fetch state and then an element sweep
// over all MAX_PES elements on the shared compare unit, and an item that
// ends a run then through a write state; in_ch.ready is high only when the
// sequencer is idle, so the block takes no new item until it is through
// with the last one.
// on the last item of a run one result appears on out_ch after the write
// state, held in an output register; a new item may be taken while it
// waits. if the receiver stalls, the next run end waits in its write
// state. cfg_we/cfg_wdata set the number of elements in use (reset 4);
// the user must write them only while idle, the block does not enforce it.
// reset (rst, synchronous) clears the sequencer, element free times and
// the output valid flag; the task tables are not cleared.
module heft_processor_selection (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hps_pkg::CFG_W-1:0] cfg_wdata,
  hps_in_if.sink                    in_ch,
  hps_out_if.source                 out_ch
);
  import hps_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0] state;
  logic [CFG_W-1:0] pe_count;
  logic mid_task;

  // item held for the duration of its work
  logic [TASK_W-1:0]   task_id;
  logic [WEIGHT_W-1:0] weight;
  logic                has_pred;
  logic [COST_W-1:0]   cost;
  logic                last;

  time_t   pred_fin;
  time_t   pred_fin_cost;
  pe_idx_t pred_pe;

  pe_idx_t idx;
  pe_idx_t best_pe;
  time_t   best_time;

  time_t pe_free  [MAX_PES];
  time_t run_ready [MAX_PES];

  logic [ENTRY_W-1:0] rd_entry;
  logic               tbl_we;
  logic [ENTRY_W-1:0] wr_entry;

  logic [PE_CNT_W-1:0] n_eff;
  step_ctrl_t ctrl;
  time_t      base;
  time_t      ready_new;
  logic       take;
  time_t      finish;
  logic       accept;
  logic       out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  // predecessor's element and finish time, one word per task
  assign tbl_we   = (state == S_WRITE) && out_free;
  assign finish   = sat_add(best_time, TIME_W'(weight));
  assign wr_entry = {best_pe, finish};

  hps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_task_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (task_id),
    .wdata (wr_entry),
    .raddr (in_ch.pred_id),
    .rdata (rd_entry)
  );

  // element count clamped to 1..MAX_PES
  always_comb begin
    if (pe_count == '0) begin
      n_eff = PE_CNT_W'(1);
    end else if (PE_CNT_W'(pe_count) > PE_CNT_W'(MAX_PES)) begin
      n_eff = PE_CNT_W'(MAX_PES);
    end else begin
      n_eff = PE_CNT_W'(pe_count);
    end
  end

  // first item of a run starts from the element free times
  assign base = mid_task ? run_ready[idx] : pe_free[idx];

  assign ctrl.has_pred = has_pred;
  assign ctrl.home     = (pred_pe == idx);
  assign ctrl.in_use   = (PE_CNT_W'(idx) < n_eff);
  assign ctrl.first    = (idx == '0);

  hps_cmp_unit u_cmp (
    .base          (base),
    .pred_fin      (pred_fin),
    .pred_fin_cost (pred_fin_cost),
    .best_time     (best_time),
    .ctrl          (ctrl),
    .ready_new     (ready_new),
    .take          (take)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mid_task <= 1'b0;
      idx      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          idx   <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          idx <= idx + PE_W'(1);
          if (idx == PE_W'(MAX_PES - 1)) begin
            mid_task <= 1'b1;
            state    <= last ? S_WRITE : S_IDLE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            mid_task <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pe_count <= PE_COUNT_RESET;
    end else if (cfg_we) begin
      pe_count <= cfg_wdata;
    end
  end

  // item capture and predecessor fetch
  always_ff @(posedge clk) begin
    if (accept) begin
      task_id  <= in_ch.task_id;
      weight   <= in_ch.task_weight;
      has_pred <= in_ch.has_pred;
      cost     <= in_ch.comm_cost;
      last     <= in_ch.last_pred;
    end
    if (state == S_FETCH) begin
      pred_fin      <= rd_entry[TIME_W-1:0];
      pred_pe       <= rd_entry[ENTRY_W-1:TIME_W];
      pred_fin_cost <= sat_add(rd_entry[TIME_W-1:0], TIME_W'(cost));
    end
  end

  // ready sweep, one element a cycle, minimum tracked alongside
  always_ff @(posedge clk) begin
    if (state == S_SWEEP) begin
      run_ready[idx] <= ready_new;
      if (take) begin
        best_pe   <= idx;
        best_time <= ready_new;
      end
    end
  end

  // element free times
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PES; i++) begin
        pe_free[i] <= '0;
      end
    end else if (tbl_we) begin
      pe_free[best_pe] <= finish;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (tbl_we) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      out_ch.placed_task <= task_id;
      out_ch.chosen_pe   <= best_pe;
      out_ch.start_time  <= best_time;
      out_ch.finish_time <= finish;
    end
  end

endmodule

>>> sv/hps_ram.sv
module hps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hps_cmp_unit.sv
module hps_cmp_unit (
  input  hps_pkg::time_t      base,
  input  hps_pkg::time_t      pred_fin,
  input  hps_pkg::time_t      pred_fin_cost,
  input  hps_pkg::time_t      best_time,
  input  hps_pkg::step_ctrl_t ctrl,
  output hps_pkg::time_t      ready_new,
  output logic                take
);
  import hps_pkg::*;

  time_t cand;

  always_comb begin
    // arrival of the predecessor's data on this element
    cand = ctrl.home ? pred_fin : pred_fin_cost;
    if (ctrl.has_pred && (cand > base)) begin
      ready_new = cand;
    end else begin
      ready_new = base;
    end
    // strict less keeps the lowest index on a tie
    take = ctrl.in_use && (ctrl.first || (ready_new < best_time));
  end

endmodule

>>> tb/hps_placement_checker.sv
module hps_placement_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hps_pkg::CFG_W-1:0] cfg_wdata,
  hps_in_if                         in_ch,
  hps_out_if                        out_ch,
  output int unsigned               fails,
  output int unsigned               outstanding
);
  import hps_pkg::*;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    pe_idx_t           pe;
    time_t             start;
    time_t             finish;
  } placement_t;

  pe_idx_t          task_pe     [MAX_TASKS];
  time_t            task_finish [MAX_TASKS];
  time_t            pe_free     [MAX_PES];
  time_t            ready_at    [MAX_PES];
  bit               in_run;
  logic [CFG_W-1:0] pes_used;
  placement_t       expected_placements [$];

  function automatic time_t add_clipped(input time_t a, input time_t b);
    logic [TIME_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[TIME_W] ? {TIME_W{1'b1}} : total[TIME_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (fails < 100) $display("%0t placement mismatch: %s", $time, msg);
    fails++;
  endtask

  // one input transfer: raise ready times, place the task at the end of a run
  task automatic predict_placement(input logic [TASK_W-1:0] tid,
                                   input logic [WEIGHT_W-1:0] weight,
                                   input logic with_pred, input logic [TASK_W-1:0] pid,
                                   input logic [COST_W-1:0] cost, input logic run_end);
    time_t      cand;
    time_t      best_start;
    int         n;
    int         best;
    placement_t p;
    if (!in_run) for (int i = 0; i < MAX_PES; i++) ready_at[i] = pe_free[i];
    in_run = 1'b1;
    if (with_pred) begin
      for (int i = 0; i < MAX_PES; i++) begin
        cand = (task_pe[pid] == PE_W'(i)) ? task_finish[pid]
                                          : add_clipped(task_finish[pid], TIME_W'(cost));
        if (cand > ready_at[i]) ready_at[i] = cand;
      end
    end
    if (run_end) begin
      n = int'(pes_used);
      if (n < 1) n = 1;
      if (n > MAX_PES) n = MAX_PES;
      best = 0;
      best_start = ready_at[0];
      for (int i = 1; i < n; i++) begin
        if (ready_at[i] < best_start) begin
          best_start = ready_at[i];
          best = i;
        end
      end
      p.task_id = tid;
      p.pe      = PE_W'(best);
      p.start   = best_start;
      p.finish  = add_clipped(best_start, TIME_W'(weight));
      task_pe[tid]     = p.pe;
      task_finish[tid] = p.finish;
      pe_free[best]    = p.finish;
      in_run = 1'b0;
      expected_placements.push_back(p);
    end
  endtask

  task automatic check_placement();
    placement_t want;
    if (expected_placements.size() == 0) begin
      report_mismatch($sformatf("result for task %0d with none pending", out_ch.placed_task));
      return;
    end
    want = expected_placements.pop_front();
    if (out_ch.placed_task !== want.task_id)
      report_mismatch($sformatf("placed_task %0d, want %0d", out_ch.placed_task, want.task_id));
    if (out_ch.chosen_pe !== want.pe)
      report_mismatch($sformatf("task %0d chosen_pe %0d, want %0d",
                                want.task_id, out_ch.chosen_pe, want.pe));
    if (out_ch.start_time !== want.start)
      report_mismatch($sformatf("task %0d start_time %0d, want %0d",
                                want.task_id, out_ch.start_time, want.start));
    if (out_ch.finish_time !== want.finish)
      report_mismatch($sformatf("task %0d finish_time %0d, want %0d",
                                want.task_id, out_ch.finish_time, want.finish));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PES; i++) begin
        pe_free[i]  = '0;
        ready_at[i] = '0;
      end
      in_run   = 1'b0;
      pes_used = PE_COUNT_RESET;
      fails    = 0;
      expected_placements.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_placement();
      if (in_ch.valid && in_ch.ready)
        predict_placement(in_ch.task_id, in_ch.task_weight, in_ch.has_pred,
                          in_ch.pred_id, in_ch.comm_cost, in_ch.last_pred);
      if (cfg_we) pes_used = cfg_wdata;
    end
    outstanding <= expected_placements.size();
  end

endmodule

>>> tb/tb_heft_processor_selection.sv
module tb_heft_processor_selection;
  import hps_pkg::*;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned in_flight;

  // idling odds per cycle, in percent
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  int unsigned       items_sent = 0;
  logic [TASK_W-1:0] placed_ids [$];

  // element counts per random phase: extremes, out-of-range values, one random
  int unsigned pe_plan [9] = '{16, 1, 0, 31, 7, 17, 2, 5, 16};

  hps_in_if  in_ch ();
  hps_out_if out_ch ();

  heft_processor_selection uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  hps_placement_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fails       (mismatches),
    .outstanding (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure at the current stall odds
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // time values: about half small so that ready times stay close, with both extremes
  function automatic logic [15:0] rand_span();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // predecessor drawn from tasks already placed, often a recent one for deep chains
  function automatic logic [TASK_W-1:0] pick_pred();
    int n;
    n = placed_ids.size();
    if (n > 8 && $urandom_range(0, 1) == 1) return placed_ids[n - 1 - $urandom_range(0, 7)];
    return placed_ids[$urandom_range(0, n - 1)];
  endfunction

  // one input transfer; valid stays high afterwards unless the caller drops it
  task automatic send_item(input logic [TASK_W-1:0] tid, input logic [WEIGHT_W-1:0] weight,
                           input logic with_pred, input logic [TASK_W-1:0] pid,
                           input logic [COST_W-1:0] cost, input logic run_end);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.task_id     <= tid;
    in_ch.task_weight <= weight;
    in_ch.has_pred    <= with_pred;
    in_ch.pred_id     <= pid;
    in_ch.comm_cost   <= cost;
    in_ch.last_pred   <= run_end;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    // the task counts as placed once its closing item has gone in
    if (run_end) placed_ids.push_back(tid);
  endtask

  // hold off until every placement is out, then let a last item without result finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_pe_count(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // a random task run: predecessors with random costs, sometimes empty items
  // in the middle and sometimes an empty closing item; non-closing items carry
  // junk task id and weight, which must be ignored
  task automatic place_random_task();
    logic [TASK_W-1:0]   tid;
    logic [WEIGHT_W-1:0] weight;
    int                  npred;
    int                  pick;
    bit                  empty_close;
    tid    = TASK_W'($urandom_range(0, MAX_TASKS - 1));
    weight = rand_span();
    pick   = $urandom_range(0, 99);
    if (pick < 12) npred = 0;
    else if (pick < 80) npred = $urandom_range(1, 3);
    else npred = $urandom_range(4, 8);
    empty_close = ($urandom_range(0, 7) == 0);
    if (npred == 0) begin
      send_item(tid, weight, 1'b0, pick_pred(), rand_span(), 1'b1);
    end else begin
      for (int k = 0; k < npred; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(TASK_W'($urandom), rand_span(), 1'b0, pick_pred(), rand_span(), 1'b0);
        if (k == npred - 1 && !empty_close)
          send_item(tid, weight, 1'b1, pick_pred(), rand_span(), 1'b1);
        else
          send_item(TASK_W'($urandom), rand_span(), 1'b1, pick_pred(), rand_span(), 1'b0);
      end
      if (empty_close) send_item(tid, weight, 1'b0, pick_pred(), rand_span(), 1'b1);
    end
  endtask

  initial begin
    int unsigned target;
    logic [CFG_W-1:0] pes;

    in_ch.valid       = 1'b0;
    in_ch.task_id     = '0;
    in_ch.task_weight = '0;
    in_ch.has_pred    = 1'b0;
    in_ch.pred_id     = '0;
    in_ch.comm_cost   = '0;
    in_ch.last_pred   = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset element count of four
    gap_pct   = 9;
    stall_pct = 57;
    // source tasks at the field extremes; the first opens the first run after reset
    send_item(10'h000, 16'h0000, 1'b0, 10'h000, 16'h0000, 1'b1);
    send_item(10'h3FF, 16'hFFFF, 1'b0, 10'h000, 16'hFFFF, 1'b1);
    // two predecessors, full cost and zero cost
    send_item(10'h155, 16'h0009, 1'b1, 10'h000, 16'hFFFF, 1'b0);
    send_item(10'h2AA, 16'd100,  1'b1, 10'h3FF, 16'h0000, 1'b1);
    // empty item in the middle of a run
    send_item(10'h007, 16'h0003, 1'b0, 10'h2AA, 16'd123,  1'b0);
    send_item(10'h155, 16'h0001, 1'b1, 10'h2AA, 16'h0005, 1'b1);
    // task placed again, with its own earlier placement as predecessor
    send_item(10'h3FF, 16'hFFFF, 1'b1, 10'h3FF, 16'hFFFF, 1'b1);
    // several predecessors closed by an empty item
    send_item(10'h011, 16'h0022, 1'b1, 10'h000, 16'd40,   1'b0);
    send_item(10'h033, 16'h0044, 1'b1, 10'h155, 16'hFFFF, 1'b0);
    send_item(10'h055, 16'h0066, 1'b1, 10'h2AA, 16'h0000, 1'b0);
    send_item(10'h006, 16'd50,   1'b0, 10'h3FF, 16'h0000, 1'b1);
    send_item(10'h200, 16'h8000, 1'b1, 10'h006, 16'h0000, 1'b1);
    // equal sources, ties go to the lowest free element
    send_item(10'h001, 16'd10,   1'b0, 10'h200, 16'h0000, 1'b1);
    send_item(10'h002, 16'd10,   1'b0, 10'h001, 16'h0000, 1'b1);
    send_item(10'h003, 16'd10,   1'b0, 10'h002, 16'h0000, 1'b1);
    // sender pauses here until every placement has come back
    drain();

    // random phases: sender lightly idle and receiver busy, then the reverse,
    // then no idling at all; element count changes only while idle
    for (int seg = 0; seg < 9; seg++) begin
      pes = (seg == 7) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(pe_plan[seg]);
      write_pe_count(pes);
      if (seg < 3) begin
        gap_pct   = 9;
        stall_pct = 57;
      end else if (seg < 6) begin
        gap_pct   = 57;
        stall_pct = 9;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      target = items_sent + 155;
      while (items_sent < target) place_random_task();
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog for a hung handshake or a lost placement
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
